/* rtl/core/sprmf_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// sprmf_pkg
// Shared widths, types and helpers for the spike-rejecting median filter.
// ============================================================================
package sprmf_pkg;

    localparam int HISTORY_DEPTH = 5;
    localparam int SAMPLE_WIDTH  = 16;
    localparam int THRESH_WIDTH  = 16;
    localparam int CMP_W         = (SAMPLE_WIDTH > THRESH_WIDTH) ? SAMPLE_WIDTH : THRESH_WIDTH;
    localparam int RANK_W        = $clog2(HISTORY_DEPTH);
    localparam int MEDIAN_RANK   = HISTORY_DEPTH / 2;

    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(100);

    typedef logic [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [THRESH_WIDTH-1:0] thresh_t;
    typedef sample_t [HISTORY_DEPTH-1:0] hist_t;

    // One result word as it leaves the filter
    typedef struct packed {
        sample_t filtered;
        logic    median_used;
        logic    spike_confirmed;
        logic    valid_res;
    } result_t;

    // Unsigned distance between two samples
    function automatic sample_t abs_diff(input sample_t a, input sample_t b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

/* rtl/core/spike_rejecting_median_filter_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// spike_rejecting_median_filter_top
// Distance filter: rejects single-sample spikes by substituting the median
// of a short history, and follows a jump once it is confirmed.
// ============================================================================
//
//   Channel  Handshake             Word
//   -------  --------------------  ----------------------------------------
//   in       in_valid / in_ready   sample
//   out      out_valid / out_ready filtered, median_used, spike_confirmed,
//                                  valid_res
//   cfg      cfg_valid / cfg_ready cfg_data (spike threshold)
//
// One word per cycle sustained while out_ready stays high; out_valid rises
// once an accepted word has passed the input register, then the result
// register. The decision, median network and history shift fit between the
// two registers; the history update is the register loop that sets the rate.
// Reset clears the history, pending spike and primed flag, and loads a
// threshold of 100. The config port is always ready.
// A stalled output holds its word; the input register keeps accepting while
// it is empty or its word can move on in the same cycle.
// ============================================================================
module spike_rejecting_median_filter_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sprmf_pkg::sample_t sample,
    output logic               out_valid,
    input  logic               out_ready,
    output sprmf_pkg::sample_t filtered,
    output logic               median_used,
    output logic               spike_confirmed,
    output logic               valid_res,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  sprmf_pkg::thresh_t cfg_data
);

    logic               in_vld_reg;
    sprmf_pkg::sample_t in_smp_reg;
    logic               out_vld_reg;
    sprmf_pkg::result_t out_res_reg;
    sprmf_pkg::thresh_t thresh_reg;
    sprmf_pkg::result_t res;
    logic               out_free;
    logic               step;

    // Handshake: move the input word on when the result register frees up
    assign out_free  = !out_vld_reg || out_ready;
    assign step      = in_vld_reg && out_free;
    assign in_ready  = !in_vld_reg || step;
    assign cfg_ready = 1'b1;

    // Hold the threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= sprmf_pkg::THRESH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thresh_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_smp_reg <= sample;
        end
    end

    sprmf_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .sample    (in_smp_reg),
        .threshold (thresh_reg),
        .res       (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid       = out_vld_reg;
    assign filtered        = out_res_reg.filtered;
    assign median_used     = out_res_reg.median_used;
    assign spike_confirmed = out_res_reg.spike_confirmed;
    assign valid_res       = out_res_reg.valid_res;

endmodule

/* rtl/core/sprmf_median.sv */
`timescale 1ns / 1ps
// ============================================================================
// sprmf_median
// Rank-based compare network picking the median entry of the history.
// ============================================================================
module sprmf_median (
    input  sprmf_pkg::hist_t   hist,
    output sprmf_pkg::sample_t median
);

    logic [sprmf_pkg::RANK_W-1:0] rank [sprmf_pkg::HISTORY_DEPTH];

    // Rank every entry: count smaller entries, ties broken by position
    always_comb
    begin
        for (int i = 0; i < sprmf_pkg::HISTORY_DEPTH; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < sprmf_pkg::HISTORY_DEPTH; j++)
            begin
                if ((hist[j] < hist[i]) || ((hist[j] == hist[i]) && (j < i)))
                begin
                    rank[i] = rank[i] + sprmf_pkg::RANK_W'(1);
                end
            end
        end
    end

    // Select the entry whose rank sits in the middle (ranks are unique)
    always_comb
    begin
        median = '0;
        for (int i = 0; i < sprmf_pkg::HISTORY_DEPTH; i++)
        begin
            if (rank[i] == sprmf_pkg::RANK_W'(sprmf_pkg::MEDIAN_RANK))
            begin
                median = median | hist[i];
            end
        end
    end

endmodule

/* rtl/core/sprmf_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// sprmf_core
// Filter state (history, pending spike, primed flag) and the per-word
// outlier decision, median substitution and history shift.
// ============================================================================
module sprmf_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  sprmf_pkg::sample_t sample,
    input  sprmf_pkg::thresh_t threshold,
    output sprmf_pkg::result_t res
);

    sprmf_pkg::hist_t   hist_reg;
    sprmf_pkg::hist_t   hist_next;
    sprmf_pkg::hist_t   hist_eff;
    sprmf_pkg::sample_t pend_value_reg;
    sprmf_pkg::sample_t pend_value_next;
    logic               pend_flag_reg;
    logic               pend_flag_next;
    logic               primed_reg;
    sprmf_pkg::sample_t median;
    logic               outlier;
    logic               confirm;
    sprmf_pkg::sample_t result_val;

    // Before the first word the history reads as filled with the sample
    always_comb
    begin
        for (int i = 0; i < sprmf_pkg::HISTORY_DEPTH; i++)
        begin
            hist_eff[i] = primed_reg ? hist_reg[i] : sample;
        end
    end

    sprmf_median u_median (
        .hist   (hist_eff),
        .median (median)
    );

    // Classify the sample and pick the output value
    always_comb
    begin
        outlier = sprmf_pkg::CMP_W'(sprmf_pkg::abs_diff(sample, hist_eff[0]))
                > sprmf_pkg::CMP_W'(threshold);
        confirm = outlier && pend_flag_reg
                && (sprmf_pkg::CMP_W'(sprmf_pkg::abs_diff(sample, pend_value_reg))
                    < sprmf_pkg::CMP_W'(threshold));
        result_val = (outlier && !confirm) ? median : sample;

        res.filtered        = result_val;
        res.median_used     = outlier && !confirm;
        res.spike_confirmed = confirm;
        res.valid_res       = (result_val != '0);
    end

    // Next state: refill on confirm, otherwise shift the output in
    always_comb
    begin
        for (int i = 1; i < sprmf_pkg::HISTORY_DEPTH; i++)
        begin
            hist_next[i] = confirm ? sample : hist_eff[i-1];
        end
        hist_next[0] = result_val;

        pend_value_next = pend_value_reg;
        pend_flag_next  = 1'b0;
        if (outlier && !confirm)
        begin
            pend_value_next = sample;
            pend_flag_next  = 1'b1;
        end
    end

    // Advance the state once per processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg       <= '0;
            pend_value_reg <= '0;
            pend_flag_reg  <= 1'b0;
            primed_reg     <= 1'b0;
        end
        else if (step)
        begin
            hist_reg       <= hist_next;
            pend_value_reg <= pend_value_next;
            pend_flag_reg  <= pend_flag_next;
            primed_reg     <= 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_confirm_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.spike_confirmed |-> pend_flag_reg)
        else $error("spike confirmed with no spike pending");

    a_median_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.median_used |=> pend_flag_reg && (pend_value_reg == $past(sample)))
        else $error("rejected sample not held as pending spike");

    a_newest_is_output: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> primed_reg && (hist_reg[0] == $past(res.filtered)))
        else $error("newest history entry differs from last output");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> !(res.median_used && res.spike_confirmed))
        else $error("median substitution and spike confirm together");
`endif

endmodule

/* test/spike_rejecting_median_filter_top_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// spike_rejecting_median_filter_top_test
// Self-checking bench for the spike-rejecting median filter. A queue-fed
// driver offers samples, and a clocked monitor compares every result word
// with a bit-true predictor of history, pending spike and threshold. Covers
// directed edge cases and random walks with spikes and confirmed jumps under
// several thresholds, with random idling on both sides and two long stalls.
// ============================================================================
module spike_rejecting_median_filter_top_test;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 8;
    localparam int MAX_VALUE   = (1 << sprmf_pkg::SAMPLE_WIDTH) - 1;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    sprmf_pkg::sample_t sample;
    logic               out_valid;
    logic               out_ready;
    sprmf_pkg::sample_t filtered;
    logic               median_used;
    logic               spike_confirmed;
    logic               valid_res;
    logic               cfg_valid;
    logic               cfg_ready;
    sprmf_pkg::thresh_t cfg_data;

    // Predictor state
    sprmf_pkg::sample_t hist_mem [sprmf_pkg::HISTORY_DEPTH];
    sprmf_pkg::sample_t spike_value;
    logic               spike_pending;
    logic               hist_primed;
    sprmf_pkg::thresh_t threshold_mirror;

    sprmf_pkg::sample_t sample_backlog [$];
    sprmf_pkg::result_t expected_words [$];

    logic in_taken;
    logic gaps_on;
    logic hold_req;
    int   hold_left;
    int   walk_level;
    int   error_count;
    int   report_count;
    int   cycle_count;

    spike_rejecting_median_filter_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .filtered        (filtered),
        .median_used     (median_used),
        .spike_confirmed (spike_confirmed),
        .valid_res       (valid_res),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Median of the history: sort a copy, take the middle rank
    function automatic sprmf_pkg::sample_t history_median();
        sprmf_pkg::sample_t sorted [sprmf_pkg::HISTORY_DEPTH];
        sprmf_pkg::sample_t key;
        int                 j;
        sorted = hist_mem;
        for (int i = 1; i < sprmf_pkg::HISTORY_DEPTH; i++)
        begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j - 1] > key)
            begin
                sorted[j] = sorted[j - 1];
                j--;
            end
            sorted[j] = key;
        end
        return sorted[sprmf_pkg::HISTORY_DEPTH / 2];
    endfunction

    function automatic int distance(input int a, input int b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // Advance the filter state by one sample and return the result word
    function automatic sprmf_pkg::result_t predict_filtered_word(
        input sprmf_pkg::sample_t s);
        sprmf_pkg::result_t word;
        sprmf_pkg::sample_t value;
        value = s;
        word  = '0;
        if (!hist_primed)
        begin
            for (int i = 0; i < sprmf_pkg::HISTORY_DEPTH; i++)
                hist_mem[i] = s;
            hist_primed = 1'b1;
        end
        if (distance(int'(s), int'(hist_mem[0])) > int'(threshold_mirror))
        begin
            if (spike_pending &&
                distance(int'(s), int'(spike_value)) < int'(threshold_mirror))
            begin
                // Jump confirmed: follow it
                for (int i = 0; i < sprmf_pkg::HISTORY_DEPTH; i++)
                    hist_mem[i] = s;
                spike_pending = 1'b0;
                word.spike_confirmed = 1'b1;
            end
            else
            begin
                // Hold the outlier as pending, substitute the median
                spike_value   = s;
                spike_pending = 1'b1;
                value = history_median();
                word.median_used = 1'b1;
            end
        end
        else
        begin
            spike_pending = 1'b0;
        end
        for (int i = sprmf_pkg::HISTORY_DEPTH - 1; i > 0; i--)
            hist_mem[i] = hist_mem[i - 1];
        hist_mem[0]    = value;
        word.filtered  = value;
        word.valid_res = (value != '0);
        return word;
    endfunction

    // Record each accepted sample and predict its result
    always @(posedge clk)
    begin
        in_taken = 1'b0;
        if (rst_n && in_valid && in_ready)
        begin
            in_taken = 1'b1;
            expected_words.push_back(predict_filtered_word(sample));
        end
    end

    // Present the next sample, with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (sample_backlog.size() != 0 && !(gaps_on && $urandom_range(99) < 6))
            begin
                in_valid <= 1'b1;
                sample   <= sample_backlog.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Drive out_ready: random stalls, plus one long hold on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req)
            begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= !(gaps_on && $urandom_range(99) < 6);
            end
        end
    end

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin
        sprmf_pkg::result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                error_count++;
                if (report_count < 10)
                begin
                    report_count++;
                    $display("unexpected word: filtered=%0d median=%0b confirm=%0b valid=%0b",
                             filtered, median_used, spike_confirmed, valid_res);
                end
            end
            else
            begin
                want = expected_words.pop_front();
                if (filtered !== want.filtered || median_used !== want.median_used ||
                    spike_confirmed !== want.spike_confirmed ||
                    valid_res !== want.valid_res)
                begin
                    error_count++;
                    if (report_count < 10)
                    begin
                        report_count++;
                        $display("mismatch: expected filtered=%0d median=%0b confirm=%0b valid=%0b",
                                 want.filtered, want.median_used, want.spike_confirmed,
                                 want.valid_res);
                        $display("          actual   filtered=%0d median=%0b confirm=%0b valid=%0b",
                                 filtered, median_used, spike_confirmed, valid_res);
                    end
                end
            end
        end
    end

    function automatic int clamp_value(input int v);
        if (v < 0)
            return 0;
        if (v > MAX_VALUE)
            return MAX_VALUE;
        return v;
    endfunction

    // Pick a value that is an outlier relative to base, where one exists
    function automatic int far_from(input int base);
        int gap;
        gap = int'(threshold_mirror) + 1 + $urandom_range(5000);
        if ($urandom_range(1) == 0 && base + gap <= MAX_VALUE)
            return base + gap;
        if (base - gap >= 0)
            return base - gap;
        if (base + gap <= MAX_VALUE)
            return base + gap;
        return $urandom_range(MAX_VALUE);
    endfunction

    task automatic push_sample(input int v);
        sample_backlog.push_back(sprmf_pkg::sample_t'(clamp_value(v)));
    endtask

    // Wait until every sample is sent and every result word checked
    task automatic wait_drained();
        do
            @(posedge clk);
        while (sample_backlog.size() != 0 || in_valid || expected_words.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_threshold(input sprmf_pkg::thresh_t value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        threshold_mirror = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random walk with spikes, confirmed jumps, edge steps and noise
    task automatic queue_random_samples(input int count);
        int n;
        int pick;
        int span;
        int half;
        int v;
        n = 0;
        span = (int'(threshold_mirror) > 4000) ? 4000 : int'(threshold_mirror);
        half = (span > 1) ? span - 1 : 0;
        while (n < count)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                v = clamp_value(walk_level + $urandom_range(2 * span) - span);
                push_sample(v);
                walk_level = v;
                n++;
            end
            else if (pick < 70)
            begin
                // Single spike, then back near the level
                push_sample(far_from(walk_level));
                push_sample(walk_level + $urandom_range(2 * half) - half);
                n += 2;
            end
            else if (pick < 85)
            begin
                // Jump to a new level, confirmed by a close second sample
                v = clamp_value(far_from(walk_level));
                push_sample(v);
                push_sample(v + $urandom_range(2 * half) - half);
                walk_level = v;
                n += 2;
            end
            else if (pick < 93)
            begin
                v = int'(threshold_mirror) + $urandom_range(1);
                push_sample(($urandom_range(1) == 0) ? walk_level + v : walk_level - v);
                n++;
            end
            else
            begin
                push_sample($urandom_range(MAX_VALUE));
                n++;
            end
        end
    endtask

    task automatic run_random_phase(input sprmf_pkg::thresh_t value, input int count,
                                    input logic gaps, input logic hold);
        wait_drained();
        write_threshold(value);
        gaps_on = gaps;
        queue_random_samples(count);
        if (hold)
            hold_req = 1'b1;
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        sample           = '0;
        out_ready        = 1'b0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        in_taken         = 1'b0;
        gaps_on          = 1'b1;
        hold_req         = 1'b0;
        hold_left        = 0;
        error_count      = 0;
        report_count     = 0;
        cycle_count      = 0;
        spike_value      = '0;
        spike_pending    = 1'b0;
        hist_primed      = 1'b0;
        threshold_mirror = sprmf_pkg::THRESH_RESET;
        for (int i = 0; i < sprmf_pkg::HISTORY_DEPTH; i++)
            hist_mem[i] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset threshold: priming, edge distances, confirm and re-pend
        push_sample(1000);      // first sample fills the history
        push_sample(1050);
        push_sample(1150);      // exactly the threshold: passes
        push_sample(1251);      // one over, nothing pending: median
        push_sample(1300);      // close to pending spike: confirm
        push_sample(5000);
        push_sample(5099);      // just inside the pending window
        push_sample(9000);
        push_sample(9100);      // exactly threshold from pending: re-pend
        push_sample(9150);
        push_sample(0);
        push_sample(MAX_VALUE);
        push_sample(65500);
        push_sample(MAX_VALUE);
        push_sample(0);
        push_sample(32768);
        push_sample(21845);
        push_sample(43690);
        wait_drained();

        // Zero threshold: any change is an outlier, no confirm possible
        write_threshold('0);
        push_sample(7);
        push_sample(7);
        push_sample(8);
        push_sample(8);
        push_sample(MAX_VALUE);
        wait_drained();

        // Full threshold: nothing is an outlier
        write_threshold('1);
        push_sample(0);
        push_sample(MAX_VALUE);
        push_sample(0);

        walk_level = 20000;
        run_random_phase(sprmf_pkg::thresh_t'(100), 180, 1'b0, 1'b1);
        run_random_phase('0, 180, 1'b1, 1'b0);
        run_random_phase('1, 180, 1'b1, 1'b0);
        run_random_phase(sprmf_pkg::thresh_t'(1), 180, 1'b1, 1'b0);
        run_random_phase(sprmf_pkg::thresh_t'(37), 180, 1'b1, 1'b0);
        run_random_phase(sprmf_pkg::thresh_t'(500), 180, 1'b1, 1'b1);
        run_random_phase(sprmf_pkg::thresh_t'(2000), 180, 1'b1, 1'b0);
        run_random_phase(sprmf_pkg::thresh_t'($urandom_range(50, 5000)), 180, 1'b1, 1'b0);
        wait_drained();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/sprmf_pkg.sv
rtl/core/sprmf_median.sv
rtl/core/sprmf_core.sv
rtl/core/spike_rejecting_median_filter_top.sv
test/spike_rejecting_median_filter_top_test.sv
